// ===== hdl/wrsd_pkg.sv =====
package wrsd_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] KIND_INFO   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] ERR_BAD_TAG   = 3'd0;
   localparam logic [2:0] ERR_NO_FMT    = 3'd1;
   localparam logic [2:0] ERR_NO_DATA   = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_BAD_DEPTH = 3'd4;
   localparam logic [2:0] ERR_SHORT_FMT = 3'd5;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [15:0] DEPTH_8      = 16'd8;
   localparam logic [15:0] DEPTH_16     = 16'd16;
   localparam logic [31:0] MIN_FMT_SIZE = 32'd16;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic [15:0]        channel_count;
      logic               is_stereo;
      logic [15:0]        bits_per_sample;
      logic [31:0]        sample_rate;
      logic [31:0]        data_length;
      logic [2:0]         error_code;
      logic               last_of_run;
   } rsp_type;

   // one pending result between parser and output stage
   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] sample;
      logic [2:0]  error_code;
      logic        last;
      logic [15:0] channels;
      logic [15:0] depth;
      logic [31:0] rate;
      logic [31:0] length;
   } entry_type;

endpackage

// ===== hdl/wrsd_front.sv =====
module wrsd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  wrsd_pkg::req_type req_payload,
   output logic              push_valid,
   input  logic              push_ready,
   output wrsd_pkg::entry_type push_data
);
   import wrsd_pkg::*;

   typedef enum logic [7:0] {
      PH_RIFF      = 8'b0000_0001,
      PH_FMT_HDR   = 8'b0000_0010,
      PH_FMT_SKIP  = 8'b0000_0100,
      PH_FMT_BODY  = 8'b0000_1000,
      PH_DATA_HDR  = 8'b0001_0000,
      PH_DATA_SKIP = 8'b0010_0000,
      PH_DATA      = 8'b0100_0000,
      PH_IDLE      = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [15:0] channels_ff, channels_in;
   logic [15:0] depth_ff, depth_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic        info_only_ff, info_only_in;

   logic        fire;
   logic [7:0]  b;
   logic        eof;
   logic [31:0] tag_shift;
   logic [4:0]  count_inc;
   logic [31:0] left_dec;
   logic        has_res;
   logic        err_flag;
   logic [1:0]  res_kind;
   logic [15:0] res_sample;
   logic [2:0]  res_err;
   logic        res_last;

   assign req_ready = push_ready;
   assign fire      = req_valid & req_ready;
   assign b         = req_payload.file_byte;
   assign eof       = req_payload.end_of_file;
   assign tag_shift = {tag_ff[23:0], b};
   assign count_inc = count_ff + 5'd1;
   assign left_dec  = left_ff - 32'd1;

   assign info_only_in = csr_write_enable ? csr_write_data : info_only_ff;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      tag_in      = tag_ff;
      size_in     = size_ff;
      channels_in = channels_ff;
      depth_in    = depth_ff;
      rate_in     = rate_ff;
      left_in     = left_ff;
      low_in      = low_ff;
      has_res     = 1'b0;
      err_flag    = 1'b0;
      res_kind    = KIND_INFO;
      res_sample  = '0;
      res_err     = ERR_BAD_TAG;
      res_last    = 1'b0;

      case (phase_ff)
         PH_RIFF: begin
            tag_in   = tag_shift;
            count_in = count_inc;
            if ((count_inc == 5'd4 && tag_shift != TAG_RIFF) ||
                (count_inc == 5'd12 && tag_shift != TAG_WAVE)) begin
               has_res  = 1'b1;
               err_flag = 1'b1;
               res_kind = KIND_ERROR;
               res_err  = ERR_BAD_TAG;
               phase_in = PH_IDLE;
            end else if (count_inc == 5'd12) begin
               phase_in = PH_FMT_HDR;
               count_in = '0;
            end
         end
         PH_FMT_HDR, PH_DATA_HDR: begin
            if (count_ff == 5'd0) begin
               size_in = '0;
            end
            if (count_ff < 5'd4) begin
               tag_in = tag_shift;
            end else begin
               case (count_ff[1:0])
                  2'd0:    size_in[7:0]   = b;
                  2'd1:    size_in[15:8]  = b;
                  2'd2:    size_in[23:16] = b;
                  default: size_in[31:24] = b;
               endcase
            end
            count_in = count_inc;
            if (count_ff == 5'd7) begin
               count_in = '0;
               left_in  = size_in;
               if (phase_ff == PH_FMT_HDR && tag_ff == TAG_FMT) begin
                  if (size_in < MIN_FMT_SIZE) begin
                     has_res  = 1'b1;
                     err_flag = 1'b1;
                     res_kind = KIND_ERROR;
                     res_err  = ERR_SHORT_FMT;
                     phase_in = PH_IDLE;
                  end else begin
                     channels_in = '0;
                     depth_in    = '0;
                     rate_in     = '0;
                     phase_in    = PH_FMT_BODY;
                  end
               end else if (phase_ff == PH_DATA_HDR && tag_ff == TAG_DATA) begin
                  if (!info_only_ff && depth_ff != DEPTH_8 && depth_ff != DEPTH_16) begin
                     has_res  = 1'b1;
                     err_flag = 1'b1;
                     res_kind = KIND_ERROR;
                     res_err  = ERR_BAD_DEPTH;
                     phase_in = PH_IDLE;
                  end else begin
                     has_res  = 1'b1;
                     res_kind = KIND_INFO;
                     res_last = info_only_ff || size_in == 32'd0 ||
                                (depth_ff == DEPTH_16 && size_in < 32'd2);
                     phase_in = (size_in != 32'd0) ? PH_DATA : PH_IDLE;
                  end
               end else if (size_in != 32'd0) begin
                  phase_in = (phase_ff == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
               end
            end
         end
         PH_FMT_SKIP, PH_DATA_SKIP: begin
            left_in = left_dec;
            if (left_dec == 32'd0) begin
               phase_in = (phase_ff == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
               count_in = '0;
            end
         end
         PH_FMT_BODY: begin
            case (count_ff)
               5'd2:  channels_in[7:0]  = b;
               5'd3:  channels_in[15:8] = b;
               5'd4:  rate_in[7:0]      = b;
               5'd5:  rate_in[15:8]     = b;
               5'd6:  rate_in[23:16]    = b;
               5'd7:  rate_in[31:24]    = b;
               5'd14: depth_in[7:0]     = b;
               5'd15: depth_in[15:8]    = b;
               default: ;
            endcase
            // saturates past the last format field
            count_in = (count_ff == 5'd16) ? count_ff : count_inc;
            left_in  = left_dec;
            if (left_dec == 32'd0) begin
               phase_in = PH_DATA_HDR;
               count_in = '0;
            end
         end
         PH_DATA: begin
            left_in = left_dec;
            if (!info_only_ff) begin
               if (depth_ff == DEPTH_8) begin
                  has_res    = 1'b1;
                  res_kind   = KIND_SAMPLE;
                  res_sample = {b, 8'd0};
                  res_last   = left_dec == 32'd0;
               end else if (!count_ff[0]) begin
                  low_in = b;
               end else begin
                  has_res    = 1'b1;
                  res_kind   = KIND_SAMPLE;
                  res_sample = {b, low_ff};
                  res_last   = left_dec < 32'd2;
               end
            end
            count_in = {4'd0, ~count_ff[0]};
            if (left_dec == 32'd0) begin
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase

      if (eof) begin
         if (!err_flag && phase_in != PH_IDLE) begin
            has_res    = 1'b1;
            res_kind   = KIND_ERROR;
            res_sample = '0;
            res_last   = 1'b0;
            case (phase_in)
               PH_RIFF:                  res_err = ERR_BAD_TAG;
               PH_FMT_HDR, PH_FMT_SKIP:  res_err = ERR_NO_FMT;
               PH_DATA:                  res_err = ERR_TRUNCATED;
               default:                  res_err = ERR_NO_DATA;
            endcase
         end
         phase_in    = PH_RIFF;
         count_in    = '0;
         tag_in      = '0;
         size_in     = '0;
         channels_in = '0;
         depth_in    = '0;
         rate_in     = '0;
         left_in     = '0;
         low_in      = '0;
      end
   end

   assign push_valid          = fire & has_res;
   assign push_data.kind       = res_kind;
   assign push_data.sample     = res_sample;
   assign push_data.error_code = res_err;
   assign push_data.last       = res_last;
   assign push_data.channels   = channels_ff;
   assign push_data.depth      = depth_ff;
   assign push_data.rate       = rate_ff;
   assign push_data.length     = (phase_ff == PH_FMT_HDR || phase_ff == PH_DATA_HDR) ?
                                 size_in : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_RIFF;
         count_ff     <= '0;
         tag_ff       <= '0;
         size_ff      <= '0;
         channels_ff  <= '0;
         depth_ff     <= '0;
         rate_ff      <= '0;
         left_ff      <= '0;
         low_ff       <= '0;
         info_only_ff <= 1'b0;
      end else begin
         info_only_ff <= info_only_in;
         if (fire) begin
            phase_ff    <= phase_in;
            count_ff    <= count_in;
            tag_ff      <= tag_in;
            size_ff     <= size_in;
            channels_ff <= channels_in;
            depth_ff    <= depth_in;
            rate_ff     <= rate_in;
            left_ff     <= left_in;
            low_ff      <= low_in;
         end
      end
   end

endmodule

// ===== hdl/wrsd_queue.sv =====
module wrsd_queue #(
   parameter int DEPTH = wrsd_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  wrsd_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output wrsd_pkg::entry_type pop_data
);
   import wrsd_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL    = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(DEPTH - 1);

   entry_type         mem_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = count_ff != FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_IX) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_IX) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/wrsd_back.sv =====
module wrsd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  wrsd_pkg::entry_type pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wrsd_pkg::rsp_type   rsp_payload
);
   import wrsd_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    is_fmt;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign is_fmt    = pop_data.kind != KIND_ERROR;

   // error results carry only the code
   always_comb begin
      rsp_data_in.kind            = pop_data.kind;
      rsp_data_in.sample          = is_fmt ? pop_data.sample : '0;
      rsp_data_in.channel_count   = is_fmt ? pop_data.channels : '0;
      rsp_data_in.is_stereo       = is_fmt && pop_data.channels == 16'd2;
      rsp_data_in.bits_per_sample = is_fmt ? pop_data.depth : '0;
      rsp_data_in.sample_rate     = is_fmt ? pop_data.rate : '0;
      rsp_data_in.data_length     = is_fmt ? pop_data.length : '0;
      rsp_data_in.error_code      = is_fmt ? ERR_BAD_TAG : pop_data.error_code;
      rsp_data_in.last_of_run     = is_fmt && pop_data.last;
   end

   assign rsp_valid_in = pop_ready ? pop_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ===== hdl/wav_riff_stream_decoder.sv =====
// Parses a RIFF/WAVE byte stream, one byte per request per cycle, and returns the
// format info, decoded 16-bit samples or an error code as responses. The parser
// accepts a byte every cycle as long as its result queue (QUEUE_DEPTH entries) has
// room; a result reaches rsp through the queue and then the output register. Bytes
// that give no result also wait while the queue is full. The user must write info_only
// through csr_write_enable/csr_write_data between files; the block does not enforce this.
module wav_riff_stream_decoder #(
   parameter int QUEUE_DEPTH = wrsd_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  wrsd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wrsd_pkg::rsp_type rsp_payload
);
   import wrsd_pkg::*;

   logic      push_valid;
   logic      push_ready;
   entry_type push_data;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_data;

   wrsd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   wrsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   wrsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== hdl/wrsd_checker.sv =====
module wrsd_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wrsd_pkg::rsp_type rsp_payload
);
   import wrsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped or changed while stalled");

   a_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == KIND_ERROR |->
         rsp_payload.data_length == '0 && rsp_payload.sample == '0 &&
         !rsp_payload.last_of_run && rsp_payload.channel_count == '0)
      else $error("error response carries format fields");

   a_stereo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.is_stereo ==
         (rsp_payload.kind != KIND_ERROR && rsp_payload.channel_count == 16'd2))
      else $error("is_stereo disagrees with channel count");

   a_sample_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind != KIND_ERROR |-> rsp_payload.error_code == '0)
      else $error("error code set on a non-error response");

endmodule

bind wav_riff_stream_decoder wrsd_checker u_wrsd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import wrsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASE_REQUESTS = 340;
   localparam int PHASE_COUNT = 5;
   localparam int MAX_DATA_BYTES = 48;

   typedef enum logic [7:0] {
      PH_RIFF      = 8'b0000_0001,
      PH_FMT_HDR   = 8'b0000_0010,
      PH_FMT_SKIP  = 8'b0000_0100,
      PH_FMT_BODY  = 8'b0000_1000,
      PH_DATA_HDR  = 8'b0001_0000,
      PH_DATA_SKIP = 8'b0010_0000,
      PH_DATA      = 8'b0100_0000,
      PH_IDLE      = 8'b1000_0000
   } parse_phase_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
      logic       gives_error;
      logic [2:0] error_code;
   } header_case_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // decoder state as the block should hold it
   parse_phase_type dec_phase = PH_RIFF;
   logic [31:0]  dec_count = '0;
   logic [31:0]  dec_tag = '0;
   logic [31:0]  dec_size = '0;
   logic [15:0]  dec_chans = '0;
   logic [15:0]  dec_depth = '0;
   logic [31:0]  dec_rate = '0;
   logic [31:0]  dec_left = '0;
   logic [7:0]   dec_low = '0;
   logic         dec_info_only = 1'b0;

   rsp_type     awaited_results [$];
   logic [7:0]  file_bytes [$];

   int cycle_count = 0;
   int failures = 0;
   int requests_sent = 0;
   int files_sent = 0;
   int info_seen = 0;
   int samples_seen = 0;
   int errors_seen = 0;
   int burst_left = 0;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mode_left = 0;
   int stall_mode = 0;

   // broken headers, typed in: bad RIFF tag, early end, bad WAVE tag
   header_case_type header_cases [22] = '{
      {8'h52, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h49, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'h46, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h58, 1'b0, 1'b1, ERR_BAD_TAG},
      {8'hFF, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h00, 1'b1, 1'b0, ERR_BAD_TAG},
      {8'h52, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h00, 1'b1, 1'b1, ERR_BAD_TAG},
      {8'h52, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h49, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'h46, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h46, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'hFF, 1'b0, 1'b0, ERR_BAD_TAG}, {8'hFF, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'hFF, 1'b0, 1'b0, ERR_BAD_TAG}, {8'hFF, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'h57, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h41, 1'b0, 1'b0, ERR_BAD_TAG},
      {8'h56, 1'b0, 1'b0, ERR_BAD_TAG}, {8'h58, 1'b0, 1'b1, ERR_BAD_TAG},
      {8'h00, 1'b1, 1'b0, ERR_BAD_TAG}, {8'hFF, 1'b1, 1'b1, ERR_BAD_TAG}
   };

   wav_riff_stream_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic rsp_type format_result(logic [1:0] kind, logic [15:0] smp,
                                             logic [2:0] code, logic last);
      rsp_type r;
      r = '0;
      r.kind = kind;
      if (kind == KIND_ERROR) begin
         r.error_code = code;
      end else begin
         r.sample = smp;
         r.channel_count = dec_chans;
         r.is_stereo = (dec_chans == 16'd2);
         r.bits_per_sample = dec_depth;
         r.sample_rate = dec_rate;
         r.data_length = dec_size;
         r.last_of_run = last;
      end
      return r;
   endfunction

   function automatic bit decode_wav_byte(input req_type r, output rsp_type res);
      logic [7:0] b;
      logic [2:0] code;
      bit got;
      bit failed;
      b = r.file_byte;
      got = 1'b0;
      failed = 1'b0;
      res = '0;
      case (dec_phase)
         PH_RIFF: begin
            dec_tag = {dec_tag[23:0], b};
            dec_count++;
            if ((dec_count == 4 && dec_tag != TAG_RIFF) ||
                (dec_count == 12 && dec_tag != TAG_WAVE)) begin
               res = format_result(KIND_ERROR, '0, ERR_BAD_TAG, 1'b0);
               got = 1'b1;
               failed = 1'b1;
               dec_phase = PH_IDLE;
            end else if (dec_count == 12) begin
               dec_phase = PH_FMT_HDR;
               dec_count = 0;
            end
         end
         PH_FMT_HDR, PH_DATA_HDR: begin
            if (dec_count == 0)
               dec_size = '0;
            if (dec_count < 4)
               dec_tag = {dec_tag[23:0], b};
            else
               dec_size[8*dec_count[1:0] +: 8] = b;
            dec_count++;
            if (dec_count >= 8) begin
               dec_count = 0;
               dec_left = dec_size;
               if (dec_phase == PH_FMT_HDR && dec_tag == TAG_FMT) begin
                  if (dec_size < MIN_FMT_SIZE) begin
                     res = format_result(KIND_ERROR, '0, ERR_SHORT_FMT, 1'b0);
                     got = 1'b1;
                     failed = 1'b1;
                     dec_phase = PH_IDLE;
                  end else begin
                     dec_chans = '0;
                     dec_depth = '0;
                     dec_rate = '0;
                     dec_phase = PH_FMT_BODY;
                  end
               end else if (dec_phase == PH_DATA_HDR && dec_tag == TAG_DATA) begin
                  if (!dec_info_only && dec_depth != DEPTH_8 && dec_depth != DEPTH_16) begin
                     res = format_result(KIND_ERROR, '0, ERR_BAD_DEPTH, 1'b0);
                     got = 1'b1;
                     failed = 1'b1;
                     dec_phase = PH_IDLE;
                  end else begin
                     res = format_result(KIND_INFO, '0, ERR_BAD_TAG,
                                         dec_info_only || dec_size == 0 ||
                                         (dec_depth == DEPTH_16 && dec_size < 2));
                     got = 1'b1;
                     dec_phase = (dec_size != 0) ? PH_DATA : PH_IDLE;
                  end
               end else if (dec_size != 0) begin
                  dec_phase = (dec_phase == PH_FMT_HDR) ? PH_FMT_SKIP : PH_DATA_SKIP;
               end
            end
         end
         PH_FMT_SKIP, PH_DATA_SKIP: begin
            dec_left--;
            if (dec_left == 0) begin
               dec_phase = (dec_phase == PH_FMT_SKIP) ? PH_FMT_HDR : PH_DATA_HDR;
               dec_count = 0;
            end
         end
         PH_FMT_BODY: begin
            if (dec_count == 2 || dec_count == 3)
               dec_chans[8*dec_count[0] +: 8] = b;
            else if (dec_count >= 4 && dec_count <= 7)
               dec_rate[8*dec_count[1:0] +: 8] = b;
            else if (dec_count == 14 || dec_count == 15)
               dec_depth[8*dec_count[0] +: 8] = b;
            dec_count++;
            dec_left--;
            if (dec_left == 0) begin
               dec_phase = PH_DATA_HDR;
               dec_count = 0;
            end
         end
         PH_DATA: begin
            dec_left--;
            if (!dec_info_only) begin
               if (dec_depth == DEPTH_8) begin
                  res = format_result(KIND_SAMPLE, {b, 8'h00}, ERR_BAD_TAG, dec_left == 0);
                  got = 1'b1;
               end else if (!dec_count[0]) begin
                  dec_low = b;
               end else begin
                  res = format_result(KIND_SAMPLE, {b, dec_low}, ERR_BAD_TAG, dec_left < 2);
                  got = 1'b1;
               end
            end
            dec_count++;
            if (dec_left == 0)
               dec_phase = PH_IDLE;
         end
         default: ;
      endcase

      if (r.end_of_file) begin
         if (!failed && dec_phase != PH_IDLE) begin
            case (dec_phase)
               PH_RIFF: code = ERR_BAD_TAG;
               PH_FMT_HDR, PH_FMT_SKIP: code = ERR_NO_FMT;
               PH_DATA: code = ERR_TRUNCATED;
               default: code = ERR_NO_DATA;
            endcase
            res = format_result(KIND_ERROR, '0, code, 1'b0);
            got = 1'b1;
         end
         dec_phase = PH_RIFF;
         dec_count = '0;
         dec_tag = '0;
         dec_size = '0;
         dec_chans = '0;
         dec_depth = '0;
         dec_rate = '0;
         dec_left = '0;
         dec_low = '0;
      end
      return got;
   endfunction

   function automatic string describe(rsp_type r);
      return $sformatf("kind=%0d sample=%h ch=%0d st=%0b bits=%0d rate=%0d len=%0d err=%0d last=%0b",
                       r.kind, r.sample, r.channel_count, r.is_stereo, r.bits_per_sample,
                       r.sample_rate, r.data_length, r.error_code, r.last_of_run);
   endfunction

   function automatic void push_tag(logic [31:0] t);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(t[8*i +: 8]);
   endfunction

   function automatic void push_word(logic [31:0] w);
      for (int i = 0; i < 4; i++)
         file_bytes.push_back(w[8*i +: 8]);
   endfunction

   // alt_tag stands in now and then for a random tag
   function automatic void push_junk_chunk(logic [31:0] alt_tag);
      int unsigned n;
      n = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0)
         push_tag(alt_tag);
      else
         push_tag($urandom);
      push_word(n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_request(req_type r, bit from_table, bit table_hit, rsp_type table_rsp);
      rsp_type res;
      bit got;
      int unsigned gap;
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = decode_wav_byte(r, res);
      if (from_table) begin
         got = table_hit;
         res = table_rsp;
      end
      if (got)
         awaited_results.push_back(res);
      requests_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic check_response(rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected response: %s", describe(got));
      end else begin
         want = awaited_results.pop_front();
         if (got.kind !== want.kind || got.sample !== want.sample ||
             got.channel_count !== want.channel_count || got.is_stereo !== want.is_stereo ||
             got.bits_per_sample !== want.bits_per_sample ||
             got.sample_rate !== want.sample_rate || got.data_length !== want.data_length ||
             got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected %s, got %s", describe(want), describe(got));
         end
      end
      case (got.kind)
         KIND_INFO: info_seen++;
         KIND_SAMPLE: samples_seen++;
         default: errors_seen++;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_response(rsp_payload);
      if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left <= $urandom_range(20, 120);
            stall_mode <= $urandom_range(0, 3);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= (cycle_count % 3 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   initial begin
      req_type     r;
      rsp_type     row_rsp;
      int unsigned phase_start;
      int unsigned shape;
      int unsigned sel;
      int unsigned fmt_size;
      int unsigned cut;
      int unsigned idx;
      logic [31:0] data_size;
      logic [31:0] rate;
      logic [15:0] chans;
      logic [15:0] depth;
      logic [7:0]  b;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 22; i++) begin
         r.file_byte = header_cases[i].file_byte;
         r.end_of_file = header_cases[i].end_of_file;
         row_rsp = '0;
         row_rsp.kind = KIND_ERROR;
         row_rsp.error_code = header_cases[i].error_code;
         send_request(r, 1'b1, header_cases[i].gives_error, row_rsp);
      end
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         csr_write_enable <= 1'b1;
         csr_write_data <= 1'(p % 2);
         @(posedge clock);
         csr_write_enable <= 1'b0;
         dec_info_only = 1'(p % 2);
         if (p == 0)
            hold_requests <= hold_requests + 1;
         phase_start = requests_sent;

         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            file_bytes.delete();
            // 0 bad tag, 1 no fmt, 2 no data, 3 short fmt, 4 odd depth,
            // 5 oversized data, 6 empty data, 7 cut short, else well formed
            shape = $urandom_range(0, 19);
            push_tag(TAG_RIFF);
            push_word($urandom);
            push_tag(TAG_WAVE);
            if (shape == 0) begin
               idx = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
               file_bytes[idx] = file_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
            end
            repeat ($urandom_range(0, 2)) push_junk_chunk(TAG_DATA);

            if (shape != 1) begin
               if (shape == 3)
                  fmt_size = $urandom_range(0, 15);
               else
                  fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 24) : 16;
               sel = $urandom_range(0, 7);
               chans = (sel < 3) ? 16'd1 : (sel < 6) ? 16'd2 : (sel == 6) ? 16'd0
                       : 16'($urandom);
               if (shape == 4)
                  depth = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
               else
                  depth = $urandom_range(0, 1) ? DEPTH_16 : DEPTH_8;
               rate = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
               push_tag(TAG_FMT);
               push_word(fmt_size);
               for (int i = 0; i < fmt_size; i++) begin
                  case (i)
                     2, 3: b = chans[8*(i-2) +: 8];
                     4, 5, 6, 7: b = rate[8*(i-4) +: 8];
                     14, 15: b = depth[8*(i-14) +: 8];
                     default: b = 8'($urandom);
                  endcase
                  file_bytes.push_back(b);
               end
               repeat ($urandom_range(0, 1)) push_junk_chunk(TAG_FMT);
            end

            if (shape != 2) begin
               if (shape == 5)
                  data_size = ($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom | 32'h8000_0000);
               else if (shape == 6)
                  data_size = '0;
               else
                  data_size = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
                              : $urandom_range(4, 40);
               push_tag(TAG_DATA);
               push_word(data_size);
               for (int i = 0; i < MAX_DATA_BYTES && i < data_size; i++)
                  file_bytes.push_back(8'($urandom));
            end

            if (shape == 7) begin
               cut = $urandom_range(1, file_bytes.size());
               while (file_bytes.size() > cut)
                  file_bytes.delete(file_bytes.size() - 1);
            end else begin
               repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom));
            end

            for (int i = 0; i < file_bytes.size(); i++) begin
               r.file_byte = file_bytes[i];
               r.end_of_file = (i == file_bytes.size() - 1);
               send_request(r, 1'b0, 1'b0, '0);
            end
            files_sent++;
         end
         drain();
      end

      $display("Run covered %0d requests in %0d generated files plus broken headers,",
               requests_sent, files_sent);
      $display("checked %0d info, %0d sample and %0d error responses with info_only 0 and 1.",
               info_seen, samples_seen, errors_seen);
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/wrsd_pkg.sv
hdl/wrsd_front.sv
hdl/wrsd_queue.sv
hdl/wrsd_back.sv
hdl/wav_riff_stream_decoder.sv
hdl/wrsd_checker.sv
bench/tb.sv
